/* hw/rtl/usp_pkg.sv */
// Shared types and constants for the UPS status line parser.
// Used by every module of the block; it depends on nothing else.
`timescale 1ns / 1ps

package usp_pkg;

   // Longest accepted line, counting its carriage return.
   localparam int LINE_MAX = 256;
   localparam int LINE_BYTES_W = $clog2(LINE_MAX);

   localparam logic [7:0] BYTE_CR = 8'h0D;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_ONE = 8'h31;

   localparam logic [3:0] TOKEN_SPACES = 4'd7;
   localparam logic [3:0] SPACES_MAX = 4'd15;
   localparam logic [2:0] TOKEN_POS_MAX = 3'd7;
   localparam logic [7:0] COUNT_MAX = 8'hFF;
   localparam logic [7:0] THRESHOLD_RESET = 8'd5;

   // Positions within the eighth token that carry the status flags.
   localparam logic [2:0] POS_UTILITY_FAIL = 3'd0;
   localparam logic [2:0] POS_BATTERY_LOW = 3'd1;
   localparam logic [2:0] POS_UPS_FAILED = 3'd3;

   typedef enum logic [1:0] {
      LINE_SHORT = 2'd0,
      LINE_ACK = 2'd1,
      LINE_STATUS = 2'd2,
      LINE_MALFORMED = 2'd3
   } line_kind_type;

   typedef struct packed {
      logic [LINE_BYTES_W-1:0] line_bytes;
      logic [3:0] spaces_seen;
      logic [2:0] token_pos;
      logic [2:0] captured;
      logic overflow;
   } line_state_type;

   typedef struct packed {
      line_kind_type line_kind;
      logic utility_fail_now;
      logic battery_low_now;
      logic ups_failed_now;
      logic power_abnormal_alarm;
      logic battery_low_alarm;
      logic ac_off_alarm;
   } result_type;

endpackage

/* hw/rtl/usp_line_tracker.sv */
// Per-line scan state: byte count, space count and eighth-token flag capture.
// Depends on usp_pkg.
`timescale 1ns / 1ps

module usp_line_tracker
   import usp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic step_en,
   input  logic [7:0] rx_byte,
   output line_state_type line_state
);

   line_state_type state_ff;
   line_state_type state_in;

   always_comb begin
      state_in = state_ff;
      if (step_en) begin
         if (rx_byte == BYTE_CR) begin
            state_in = '0;
         end else begin
            if (state_ff.line_bytes == LINE_BYTES_W'(LINE_MAX - 1)) begin
               state_in.overflow = 1'b1;
            end else begin
               state_in.line_bytes = state_ff.line_bytes + 1'b1;
            end
            if (rx_byte == BYTE_SPACE) begin
               if (state_ff.spaces_seen != SPACES_MAX) begin
                  state_in.spaces_seen = state_ff.spaces_seen + 1'b1;
               end
               state_in.token_pos = '0;
            end else if (state_ff.spaces_seen == TOKEN_SPACES) begin
               if (rx_byte == BYTE_ONE) begin
                  if (state_ff.token_pos == POS_UTILITY_FAIL) begin
                     state_in.captured[0] = 1'b1;
                  end
                  if (state_ff.token_pos == POS_BATTERY_LOW) begin
                     state_in.captured[1] = 1'b1;
                  end
                  if (state_ff.token_pos == POS_UPS_FAILED) begin
                     state_in.captured[2] = 1'b1;
                  end
               end
               if (state_ff.token_pos != TOKEN_POS_MAX) begin
                  state_in.token_pos = state_ff.token_pos + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign line_state = state_ff;

endmodule

/* hw/rtl/usp_status_eval.sv */
// Line classification at carriage return, consecutive-line counters and alarms.
// Depends on usp_pkg.
`timescale 1ns / 1ps

module usp_status_eval
   import usp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic line_end,
   input  line_state_type line_state,
   input  logic [7:0] alarm_threshold,
   output result_type result
);

   logic [7:0] fail_count_ff, fail_count_in;
   logic [7:0] battery_low_count_ff, battery_low_count_in;
   logic [7:0] ac_stop_count_ff, ac_stop_count_in;
   line_kind_type kind;
   logic [2:0] now_bits;

   function automatic logic [7:0] bump(input logic [7:0] count, input logic present);
      logic [7:0] next;
      next = '0;
      if (present) begin
         next = (count == COUNT_MAX) ? count : count + 1'b1;
      end
      return next;
   endfunction

   always_comb begin
      if (line_state.overflow) begin
         kind = LINE_MALFORMED;
      end else if (line_state.line_bytes <= LINE_BYTES_W'(2)) begin
         kind = LINE_SHORT;
      end else if (line_state.line_bytes == LINE_BYTES_W'(3)) begin
         kind = LINE_ACK;
      end else if (line_state.spaces_seen != TOKEN_SPACES) begin
         kind = LINE_MALFORMED;
      end else begin
         kind = LINE_STATUS;
      end
   end

   assign now_bits = (kind == LINE_STATUS) ? line_state.captured : 3'b000;

   always_comb begin
      fail_count_in = fail_count_ff;
      battery_low_count_in = battery_low_count_ff;
      ac_stop_count_in = ac_stop_count_ff;
      if (kind == LINE_STATUS) begin
         ac_stop_count_in = bump(ac_stop_count_ff, now_bits[0]);
         battery_low_count_in = bump(battery_low_count_ff, now_bits[1]);
         fail_count_in = bump(fail_count_ff, now_bits[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_count_ff <= '0;
         battery_low_count_ff <= '0;
         ac_stop_count_ff <= '0;
      end else if (line_end) begin
         fail_count_ff <= fail_count_in;
         battery_low_count_ff <= battery_low_count_in;
         ac_stop_count_ff <= ac_stop_count_in;
      end
   end

   // Alarms look at the counters as they stand after this line.
   always_comb begin
      result.line_kind = kind;
      result.utility_fail_now = now_bits[0];
      result.battery_low_now = now_bits[1];
      result.ups_failed_now = now_bits[2];
      result.power_abnormal_alarm = (fail_count_in >= alarm_threshold);
      result.battery_low_alarm = (battery_low_count_in >= alarm_threshold);
      result.ac_off_alarm = (ac_stop_count_in >= alarm_threshold);
   end

endmodule

/* hw/rtl/ups_status_line_parser.sv */
// Top level of the UPS status line parser: input register, line scan, result register.
// Depends on usp_pkg, usp_line_tracker and usp_status_eval.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_rx_byte (one reply byte per beat)
// rsp_      out        rsp_valid / rsp_ready  rsp_line_kind, three flags, three alarms
// csr_      in         csr_wr_en              csr_wr_data (alarm threshold)
//
// One byte beat is taken every cycle unless a carriage return is held in the input
// register. A byte waits in the input register, then the line scan updates from it;
// a carriage return also loads the result register, so rsp_valid rises in the
// cycle after it leaves the input register and holds until rsp_ready takes the beat.
// Reset clears the line state, the counters and both valid flags, and sets the threshold
// to five. A stalled result only holds back a carriage return waiting in the input
// register; ordinary bytes keep flowing past a full result register.

module ups_status_line_parser
   import usp_pkg::*;
(
   input  logic clock,
   input  logic reset,

   input  logic req_valid,
   output logic req_ready,
   input  logic [7:0] req_rx_byte,

   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_line_kind,
   output logic rsp_utility_fail_now,
   output logic rsp_battery_low_now,
   output logic rsp_ups_failed_now,
   output logic rsp_power_abnormal_alarm,
   output logic rsp_battery_low_alarm,
   output logic rsp_ac_off_alarm,

   input  logic csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   logic [7:0] threshold_ff;

   logic in_is_cr;
   logic out_free;
   logic advance;
   logic line_end;
   line_state_type line_state;
   result_type result;

   // A byte in the input register moves on unless it is a carriage return
   // and the result register still holds a beat nobody has taken.
   assign in_is_cr = (in_byte_ff == BYTE_CR);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance = in_valid_ff && (!in_is_cr || out_free);
   assign line_end = advance && in_is_cr;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (line_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (line_end) begin
         rsp_data_ff <= result;
      end
   end

   usp_line_tracker u_line_tracker (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .rx_byte    (in_byte_ff),
      .line_state (line_state)
   );

   usp_status_eval u_status_eval (
      .clock           (clock),
      .reset           (reset),
      .line_end        (line_end),
      .line_state      (line_state),
      .alarm_threshold (threshold_ff),
      .result          (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_line_kind = rsp_data_ff.line_kind;
   assign rsp_utility_fail_now = rsp_data_ff.utility_fail_now;
   assign rsp_battery_low_now = rsp_data_ff.battery_low_now;
   assign rsp_ups_failed_now = rsp_data_ff.ups_failed_now;
   assign rsp_power_abnormal_alarm = rsp_data_ff.power_abnormal_alarm;
   assign rsp_battery_low_alarm = rsp_data_ff.battery_low_alarm;
   assign rsp_ac_off_alarm = rsp_data_ff.ac_off_alarm;

endmodule
